// ===== hw/rtl/freq_group_rank_id_top_defines.svh =====
// Assertion macros for the top RTL file of the frequency group block.
`ifndef FREQ_GROUP_RANK_ID_TOP_DEFINES_SVH
`define FREQ_GROUP_RANK_ID_TOP_DEFINES_SVH

// Clocked check that is switched off while reset is asserted.
`define FGR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Clocked check that also holds during reset.
`define FGR_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== hw/rtl/fgr_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package fgr_pkg;

  localparam int MaxRanks = 64;
  localparam int RankW    = $clog2(MaxRanks);
  localparam int CntW     = $clog2(MaxRanks + 1);

  localparam int FreqW    = 44;
  localparam int RamW     = FreqW + 1;
  localparam int TolW     = 16;
  localparam int OwnW     = 6;
  localparam int GroupW   = 6;

  localparam logic [GroupW-1:0] GroupMax = {GroupW{1'b1}};

  localparam int InDataW  = ((FreqW + 7) / 8) * 8;
  localparam int OutDataW = ((GroupW + 7) / 8) * 8;

  localparam int CfgAddrW = 1;
  localparam int CfgDataW = TolW;

  localparam logic [CfgAddrW-1:0] CfgOwnRank   = 1'd0;
  localparam logic [CfgAddrW-1:0] CfgTolerance = 1'd1;

  localparam logic [TolW-1:0] TolReset = 16'd16;

endpackage

`default_nettype wire

// ===== hw/rtl/fgr_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module fgr_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/freq_group_rank_id_top.sv =====
// Loading: one rank per cycle while s_axis_tready is high, i.e. in the idle state.
// After the beat marked last: the own-rank read (no capture if it is not loaded), then
// up to min(n, 63) + 1 scans, each followed by an evaluation, then the result beat,
// which waits while an earlier beat is not taken. All reads use one memory read port.
// Reset clears the sequencer and load count; own_rank resets to 0 and tolerance to 16.
// The rank memory is not cleared.
`timescale 1ns / 1ps
`default_nettype none
`include "freq_group_rank_id_top_defines.svh"

module freq_group_rank_id_top (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // Input stream: tdata = rank_freq, tuser = rank_active, tlast = is_last.
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  input  wire logic [fgr_pkg::InDataW-1:0]   s_axis_tdata,  // [43:0] rank_freq
  input  wire logic [0:0]                    s_axis_tuser,  // [0] rank_active
  input  wire logic                          s_axis_tlast,
  // Result stream.
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  output logic      [fgr_pkg::OutDataW-1:0]  m_axis_tdata,  // [5:0] group_id
  // Configuration write port.
  input  wire logic                          cfg_we_i,
  input  wire logic [fgr_pkg::CfgAddrW-1:0]  cfg_addr_i,
  input  wire logic [fgr_pkg::CfgDataW-1:0]  cfg_data_i
);

  localparam logic [2:0] StIdle   = 3'd0;
  localparam logic [2:0] StOwn    = 3'd1;
  localparam logic [2:0] StOwnCap = 3'd2;
  localparam logic [2:0] StScan   = 3'd3;
  localparam logic [2:0] StEval   = 3'd4;
  localparam logic [2:0] StOut    = 3'd5;

  logic [2:0] state_q, state_d;

  logic [fgr_pkg::OwnW-1:0]   own_rank_q;
  logic [fgr_pkg::TolW-1:0]   tolerance_q;
  logic [fgr_pkg::CntW-1:0]   cnt_q, cnt_d;
  logic                       seen_q, seen_d;
  logic [fgr_pkg::FreqW-1:0]  first_freq_q, first_freq_d;
  logic [fgr_pkg::CntW-1:0]   rd_addr_q, rd_addr_d;
  logic                       rd_vld_q;
  logic                       found_q, found_d;
  logic                       first_scan_q, first_scan_d;
  logic                       own_present_q, own_present_d;
  logic [fgr_pkg::GroupW-1:0] gid_q, gid_d;
  logic                       out_valid_q, out_valid_d;
  logic [fgr_pkg::GroupW-1:0] group_id_q, group_id_d;

  logic [fgr_pkg::FreqW-1:0]  best_q, best_d;
  logic [fgr_pkg::FreqW:0]    thr_q, thr_d;
  logic [fgr_pkg::FreqW-1:0]  own_val_q, own_val_d;

  logic                       in_beat;
  logic                       ram_we;
  logic                       ram_re;
  logic [fgr_pkg::RankW-1:0]  ram_raddr;
  logic [fgr_pkg::RamW-1:0]   ram_rdata;
  logic [fgr_pkg::FreqW-1:0]  val;
  logic                       take;
  logic                       own_present;
  logic [fgr_pkg::GroupW-1:0] gid_inc;

  assign s_axis_tready = (state_q == StIdle);
  assign in_beat       = s_axis_tvalid && s_axis_tready;
  assign ram_we        = in_beat && (cnt_q < fgr_pkg::CntW'(fgr_pkg::MaxRanks));

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = fgr_pkg::OutDataW'(group_id_q);

  fgr_ram #(
    .Width (fgr_pkg::RamW),
    .Depth (fgr_pkg::MaxRanks)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (cnt_q[fgr_pkg::RankW-1:0]),
    .wdata_i ({s_axis_tuser[0], s_axis_tdata[fgr_pkg::FreqW-1:0]}),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Inactive ranks read back as the first active frequency of the load.
  assign val = ram_rdata[fgr_pkg::FreqW] ? ram_rdata[fgr_pkg::FreqW-1:0] : first_freq_q;

  // The first scan takes the overall minimum; later scans take the smallest
  // value above the current group start plus the tolerance.
  assign take = (first_scan_q || ((fgr_pkg::FreqW + 1)'(val) > thr_q)) &&
                (!found_q || (val < best_q));

  assign own_present = ({{fgr_pkg::CntW{1'b0}}, own_rank_q} <
                        {{fgr_pkg::OwnW{1'b0}}, cnt_q});

  assign gid_inc = gid_q + fgr_pkg::GroupW'(1);

  always_comb begin
    state_d       = state_q;
    cnt_d         = cnt_q;
    seen_d        = seen_q;
    first_freq_d  = first_freq_q;
    rd_addr_d     = rd_addr_q;
    found_d       = found_q;
    first_scan_d  = first_scan_q;
    own_present_d = own_present_q;
    gid_d         = gid_q;
    out_valid_d   = out_valid_q && !m_axis_tready;
    group_id_d    = group_id_q;
    best_d        = best_q;
    thr_d         = thr_q;
    own_val_d     = own_val_q;
    ram_re        = 1'b0;
    ram_raddr     = rd_addr_q[fgr_pkg::RankW-1:0];

    unique case (state_q)
      StIdle: begin
        if (in_beat) begin
          if (ram_we) begin
            cnt_d = cnt_q + fgr_pkg::CntW'(1);
            if (s_axis_tuser[0] && !seen_q) begin
              seen_d       = 1'b1;
              first_freq_d = s_axis_tdata[fgr_pkg::FreqW-1:0];
            end
          end
          if (s_axis_tlast) begin
            state_d      = StOwn;
            rd_addr_d    = '0;
            found_d      = 1'b0;
            first_scan_d = 1'b1;
            gid_d        = '0;
          end
        end
      end
      StOwn: begin
        own_present_d = own_present;
        if (own_present) begin
          ram_re    = 1'b1;
          ram_raddr = fgr_pkg::RankW'(own_rank_q);
          state_d   = StOwnCap;
        end else begin
          state_d = StScan;
        end
      end
      StOwnCap: begin
        own_val_d = val;
        state_d   = StScan;
      end
      StScan: begin
        if (rd_addr_q < cnt_q) begin
          ram_re    = 1'b1;
          rd_addr_d = rd_addr_q + fgr_pkg::CntW'(1);
        end
        if (rd_vld_q && take) begin
          found_d = 1'b1;
          best_d  = val;
        end
        if ((rd_addr_q == cnt_q) && !rd_vld_q) begin
          state_d = StEval;
        end
      end
      StEval: begin
        rd_addr_d = '0;
        found_d   = 1'b0;
        thr_d     = (fgr_pkg::FreqW + 1)'(best_q) + (fgr_pkg::FreqW + 1)'(tolerance_q);
        if (!found_q || (own_present_q && (best_q > own_val_q))) begin
          state_d = StOut;
        end else if (first_scan_q) begin
          first_scan_d = 1'b0;
          state_d      = StScan;
        end else begin
          gid_d = gid_inc;
          // Once the id saturates no later group can change the answer.
          state_d = (gid_inc == fgr_pkg::GroupMax) ? StOut : StScan;
        end
      end
      StOut: begin
        if (!out_valid_q || m_axis_tready) begin
          out_valid_d  = 1'b1;
          group_id_d   = gid_q;
          cnt_d        = '0;
          seen_d       = 1'b0;
          first_freq_d = '0;
          state_d      = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= StIdle;
      own_rank_q    <= '0;
      tolerance_q   <= fgr_pkg::TolReset;
      cnt_q         <= '0;
      seen_q        <= 1'b0;
      first_freq_q  <= '0;
      rd_addr_q     <= '0;
      rd_vld_q      <= 1'b0;
      found_q       <= 1'b0;
      first_scan_q  <= 1'b0;
      own_present_q <= 1'b0;
      gid_q         <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q       <= state_d;
      cnt_q         <= cnt_d;
      seen_q        <= seen_d;
      first_freq_q  <= first_freq_d;
      rd_addr_q     <= rd_addr_d;
      rd_vld_q      <= ram_re;
      found_q       <= found_d;
      first_scan_q  <= first_scan_d;
      own_present_q <= own_present_d;
      gid_q         <= gid_d;
      out_valid_q   <= out_valid_d;
      if (cfg_we_i) begin
        unique case (cfg_addr_i)
          fgr_pkg::CfgOwnRank:   own_rank_q  <= cfg_data_i[fgr_pkg::OwnW-1:0];
          fgr_pkg::CfgTolerance: tolerance_q <= cfg_data_i[fgr_pkg::TolW-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    best_q     <= best_d;
    thr_q      <= thr_d;
    own_val_q  <= own_val_d;
    group_id_q <= group_id_d;
  end

  `FGR_ASSERT(a_cnt_bound, cnt_q <= fgr_pkg::CntW'(fgr_pkg::MaxRanks), "load count overran")
  `FGR_ASSERT(a_last_starts, (in_beat && s_axis_tlast) |=> (state_q == StOwn),
              "last beat lost")
  `FGR_ASSERT(a_best_above,
              (state_q == StEval && found_q && !first_scan_q) |->
              ((fgr_pkg::FreqW + 1)'(best_q) > thr_q),
              "group start not above threshold")
  `FGR_ASSERT(a_out_from_seq, $rose(m_axis_tvalid) |-> $past(state_q == StOut),
              "result beat without computation")
  `FGR_ASSERT_ALWAYS(a_no_scan_read_in_idle, (state_q == StIdle) |-> !ram_re,
                     "memory read while loading")

endmodule

`default_nettype wire
